@@ sv/ckg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckg_pkg
// Shared types, register offsets, field masks and limits of the clock
// generator register block.
// ----------------------------------------------------------------------------
package ckg_pkg;

	// register offsets from the block base
	localparam logic [15:0] OFS_SCKCR    = 16'h0020;
	localparam logic [15:0] OFS_SCKCR3   = 16'h0026;
	localparam logic [15:0] OFS_PLLCR    = 16'h0028;
	localparam logic [15:0] OFS_PLLCR2   = 16'h002a;
	localparam logic [15:0] OFS_MOSCCR   = 16'h0032;
	localparam logic [15:0] OFS_SOSCCR   = 16'h0033;
	localparam logic [15:0] OFS_LOCOCR   = 16'h0034;
	localparam logic [15:0] OFS_ILOCOCR  = 16'h0035;
	localparam logic [15:0] OFS_HOCOCR   = 16'h0036;
	localparam logic [15:0] OFS_OSCOVFSR = 16'h003c;
	localparam logic [15:0] OFS_CKOCR    = 16'h00e3;

	// implemented bits and reset values
	localparam logic [31:0] SCKCR_MASK  = 32'hff000f0f;
	localparam logic [31:0] SCKCR_RESET = 32'h33000303;
	localparam logic [15:0] SCKCR3_MASK = 16'h0700;
	localparam logic [15:0] PLLCR_MASK  = 16'h3f03;
	localparam logic [15:0] PLLCR_RESET = 16'h0f00;
	localparam logic [15:0] CKOCR_MASK  = 16'hf700;

	// bus divider codes above this divide by one
	localparam logic [3:0] BUS_DIV_MAX = 4'd6;
	localparam logic [2:0] SRC_MAX     = 3'd4;
	localparam logic [2:0] CKO_SRC_MAX = 3'd3;
	localparam logic [2:0] CKO_DIV_MAX = 3'd4;

	// divider source codes
	localparam logic [2:0] SRC_LOCO = 3'd0;
	localparam logic [2:0] SRC_HOCO = 3'd1;
	localparam logic [2:0] SRC_MAIN = 3'd2;
	localparam logic [2:0] SRC_SUB  = 3'd3;
	localparam logic [2:0] SRC_PLL  = 3'd4;

	// pll codes
	localparam logic [5:0] STC_X6   = 6'h0b;
	localparam logic [5:0] STC_X8   = 6'h0f;
	localparam logic [1:0] PLL_DIV2 = 2'd1;
	localparam logic [1:0] PLL_DIV4 = 2'd2;
	localparam logic [1:0] PLL_DIV_BAD = 2'd3;

	// pll range limits in hertz
	localparam logic [31:0] PLL_IN_MIN  = 32'd4000000;
	localparam logic [31:0] PLL_IN_MAX  = 32'd8000000;
	localparam logic [31:0] PLL_OUT_MIN = 32'd32000000;
	localparam logic [31:0] PLL_OUT_MAX = 32'd48000000;

	// oscillator frequency register indexes
	localparam logic [2:0] CFG_MAIN = 3'd0;
	localparam logic [2:0] CFG_SUB  = 3'd1;
	localparam logic [2:0] CFG_LOCO = 3'd2;
	localparam logic [2:0] CFG_HOCO = 3'd3;

	localparam logic [24:0] MAIN_HZ_RESET = 25'd0;
	localparam logic [19:0] SUB_HZ_RESET  = 20'd32768;
	localparam logic [26:0] LOCO_HZ_RESET = 27'd4000000;
	localparam logic [26:0] HOCO_HZ_RESET = 27'd32000000;

	// running source bit positions
	localparam int RUN_MAIN = 0;
	localparam int RUN_SUB  = 1;
	localparam int RUN_LOCO = 2;
	localparam int RUN_HOCO = 3;
	localparam int RUN_WDT  = 4;
	localparam logic [4:0] RUN_RESET = 5'b00100;

	typedef struct packed {
		logic        command;
		logic [15:0] reg_offset;
		logic [31:0] write_data;
	} ckg_cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] iclk_hz;
		logic [31:0] fclk_hz;
		logic [31:0] pckb_hz;
		logic [31:0] pckd_hz;
		logic [31:0] pll_hz;
		logic [31:0] clkout_hz;
		logic        write_refused;
		logic        pll_in_out_of_range;
		logic        pll_out_out_of_range;
		logic        illegal_setting;
	} ckg_result_t;

	typedef struct packed {
		logic [24:0] main_hz;
		logic [19:0] sub_hz;
		logic [26:0] loco_hz;
		logic [26:0] hoco_hz;
	} ckg_osc_t;

	typedef struct packed {
		logic [31:0] sckcr;
		logic [15:0] sckcr3;
		logic [2:0]  div_src;
		logic [15:0] pllcr;
		logic        pll_stop;
		logic        main_stop;
		logic        sub_stop;
		logic        loco_stop;
		logic        wdt_stop;
		logic        hoco_stop;
		logic [4:0]  running;
		logic [15:0] ckocr;
	} ckg_state_t;

	typedef struct packed {
		logic [31:0] iclk;
		logic [31:0] fclk;
		logic [31:0] pckb;
		logic [31:0] pckd;
		logic [31:0] pll;
		logic [31:0] clkout;
		logic        pll_in_err;
		logic        pll_out_err;
		logic        main_on;
		logic        hoco_on;
	} ckg_freq_t;

	typedef struct packed {
		logic refused;
		logic illegal;
	} ckg_flags_t;

	function automatic logic [2:0] bus_shift(input logic [3:0] code);
		return (code > BUS_DIV_MAX) ? 3'd0 : code[2:0];
	endfunction

endpackage

@@ sv/ckg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckg_regs
// Control register file: applies one write transaction and presents the
// updated register state together with the refused and illegal flags.
// ----------------------------------------------------------------------------
module ckg_regs import ckg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  ckg_cmd_t   cmd,
	output ckg_state_t nxt,
	output ckg_flags_t flags
);

	ckg_state_t  state_q;
	logic [31:0] wd;
	logic        b;

	assign wd = cmd.write_data;
	assign b  = wd[0];

	always_comb begin
		nxt   = state_q;
		flags = '0;
		if (vld && cmd.command) begin
			unique case (cmd.reg_offset)
				OFS_SCKCR: begin
					if (wd[31:28] > BUS_DIV_MAX || wd[27:24] > BUS_DIV_MAX ||
					    wd[11:8] > BUS_DIV_MAX || wd[3:0] > BUS_DIV_MAX)
						flags.illegal = 1'b1;
					nxt.sckcr = wd & SCKCR_MASK;
				end
				OFS_SCKCR3: begin
					// an illegal source is stored but the mux keeps its input
					if (wd[10:8] <= SRC_MAX)
						nxt.div_src = wd[10:8];
					else
						flags.illegal = 1'b1;
					nxt.sckcr3 = wd[15:0] & SCKCR3_MASK;
				end
				OFS_PLLCR: begin
					if (!state_q.pll_stop) begin
						flags.refused = 1'b1;
					end else begin
						nxt.pllcr = wd[15:0] & PLLCR_MASK;
						if (wd[1:0] == PLL_DIV_BAD ||
						    (wd[13:8] != STC_X6 && wd[13:8] != STC_X8))
							flags.illegal = 1'b1;
					end
				end
				OFS_PLLCR2: nxt.pll_stop = b;
				OFS_MOSCCR: begin
					nxt.main_stop         = b;
					nxt.running[RUN_MAIN] = !b;
				end
				OFS_SOSCCR: begin
					nxt.sub_stop         = b;
					nxt.running[RUN_SUB] = !b;
				end
				OFS_LOCOCR: begin
					nxt.loco_stop         = b;
					nxt.running[RUN_LOCO] = !b;
				end
				OFS_ILOCOCR: begin
					// once stopped the watchdog osc cannot be stopped by a repeated write
					if (!b)
						nxt.running[RUN_WDT] = 1'b1;
					else if (!state_q.wdt_stop)
						nxt.running[RUN_WDT] = 1'b0;
					nxt.wdt_stop = b;
				end
				OFS_HOCOCR: begin
					nxt.hoco_stop         = b;
					nxt.running[RUN_HOCO] = !b;
				end
				OFS_CKOCR: begin
					nxt.ckocr = wd[15:0] & CKOCR_MASK;
					if (!wd[15] && (wd[10:8] > CKO_SRC_MAX || wd[14:12] > CKO_DIV_MAX))
						flags.illegal = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.sckcr     <= SCKCR_RESET;
			state_q.sckcr3    <= '0;
			state_q.div_src   <= SRC_LOCO;
			state_q.pllcr     <= PLLCR_RESET;
			state_q.pll_stop  <= 1'b1;
			state_q.main_stop <= 1'b1;
			state_q.sub_stop  <= 1'b0;
			state_q.loco_stop <= 1'b0;
			state_q.wdt_stop  <= 1'b1;
			state_q.hoco_stop <= 1'b1;
			state_q.running   <= RUN_RESET;
			state_q.ckocr     <= '0;
		end else begin
			state_q <= nxt;
		end
	end

endmodule

@@ sv/ckg_freq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckg_freq
// Clock tree model: works out pll, bus and clock-out frequencies and the pll
// range checks from the register state and the oscillator frequencies.
// ----------------------------------------------------------------------------
module ckg_freq import ckg_pkg::*; (
	input  ckg_state_t st,
	input  ckg_osc_t   osc,
	output ckg_freq_t  fq
);

	logic [24:0] main_run;
	logic [27:0] main_ext;
	logic [27:0] pll_prod;
	logic [1:0]  pll_sh;
	logic [27:0] pll_raw;
	logic [31:0] pll_hz;
	logic [31:0] pll_in;
	logic [31:0] loco_run;
	logic [31:0] hoco_run;
	logic [31:0] main32;
	logic [31:0] sub_run;
	logic [31:0] div_in;
	logic [31:0] cko_src;
	logic [2:0]  cko_sel;
	logic [2:0]  cko_div;

	assign main_run = st.running[RUN_MAIN] ? osc.main_hz : '0;
	assign main_ext = 28'(main_run);
	assign main32   = 32'(main_run);
	assign loco_run = st.running[RUN_LOCO] ? 32'(osc.loco_hz) : '0;
	assign hoco_run = st.running[RUN_HOCO] ? 32'(osc.hoco_hz) : '0;
	assign sub_run  = st.running[RUN_SUB]  ? 32'(osc.sub_hz)  : '0;

	// pll multiplier: x6 as x4 + x2, unknown stc multiplies by one; the divider code picks the shift
	always_comb begin
		unique case (st.pllcr[13:8])
			STC_X6:  pll_prod = (main_ext << 2) + (main_ext << 1);
			STC_X8:  pll_prod = main_ext << 3;
			default: pll_prod = main_ext;
		endcase
		unique case (st.pllcr[1:0])
			PLL_DIV2: pll_sh = 2'd1;
			PLL_DIV4: pll_sh = 2'd2;
			default:  pll_sh = 2'd0;
		endcase
	end

	assign pll_raw = pll_prod >> pll_sh;
	assign pll_hz  = st.pll_stop ? '0 : 32'(pll_raw);
	assign pll_in  = main32 >> pll_sh;

	always_comb begin
		unique case (st.div_src)
			SRC_LOCO: div_in = loco_run;
			SRC_HOCO: div_in = hoco_run;
			SRC_MAIN: div_in = main32;
			SRC_SUB:  div_in = sub_run;
			SRC_PLL:  div_in = pll_hz;
			default:  div_in = '0;
		endcase
	end

	assign cko_sel = st.ckocr[10:8];
	assign cko_div = st.ckocr[14:12];

	always_comb begin
		unique case (cko_sel)
			SRC_LOCO: cko_src = loco_run;
			SRC_HOCO: cko_src = hoco_run;
			SRC_MAIN: cko_src = main32;
			default:  cko_src = sub_run;
		endcase
	end

	always_comb begin
		fq.iclk = div_in >> bus_shift(st.sckcr[27:24]);
		fq.fclk = div_in >> bus_shift(st.sckcr[31:28]);
		fq.pckb = div_in >> bus_shift(st.sckcr[11:8]);
		fq.pckd = div_in >> bus_shift(st.sckcr[3:0]);
		fq.pll  = pll_hz;
		if (st.ckocr[15] || cko_sel > CKO_SRC_MAX || cko_div > CKO_DIV_MAX)
			fq.clkout = '0;
		else
			fq.clkout = cko_src >> cko_div;
		fq.pll_in_err  = !st.pll_stop && (pll_in > PLL_IN_MAX || pll_in < PLL_IN_MIN);
		fq.pll_out_err = !st.pll_stop && (pll_hz > PLL_OUT_MAX || pll_hz < PLL_OUT_MIN);
		fq.main_on     = main_run != '0;
		fq.hoco_on     = hoco_run != '0;
	end

endmodule

@@ sv/clock_generator_registers.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_generator_registers
// Register window of the clock generator with derived clock frequencies.
// ----------------------------------------------------------------------------
// One register transaction can be started in every cycle; busy stays low.
// A transaction is registered when it is taken. From that register, the control
// registers and the result register are loaded together, and the result is
// shown with done high for a single cycle; results come one per cycle, in order. The
// result must be taken in that cycle: the receiver cannot stall. Every result
// carries the frequencies after the transaction.
// Oscillator frequency writes go through cfg_we/cfg_addr/cfg_wdata and are
// meant for idle periods; index 4 (watchdog oscillator) is accepted and has
// no effect on any output.
// ----------------------------------------------------------------------------
module clock_generator_registers import ckg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  ckg_cmd_t    cmd,
	output logic        done,
	output ckg_result_t result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [26:0] cfg_wdata
);

	ckg_cmd_t    cmd_s1;
	logic        vld_s1;
	ckg_osc_t    osc_q;
	ckg_state_t  nxt;
	ckg_flags_t  flags;
	ckg_freq_t   fq;
	logic [31:0] rd;
	logic        done_q;
	ckg_result_t result_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_q.main_hz <= MAIN_HZ_RESET;
			osc_q.sub_hz  <= SUB_HZ_RESET;
			osc_q.loco_hz <= LOCO_HZ_RESET;
			osc_q.hoco_hz <= HOCO_HZ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MAIN: osc_q.main_hz <= cfg_wdata[24:0];
				CFG_SUB:  osc_q.sub_hz  <= cfg_wdata[19:0];
				CFG_LOCO: osc_q.loco_hz <= cfg_wdata;
				CFG_HOCO: osc_q.hoco_hz <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ckg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s1),
		.cmd    (cmd_s1),
		.nxt    (nxt),
		.flags  (flags)
	);

	ckg_freq u_freq (
		.st  (nxt),
		.osc (osc_q),
		.fq  (fq)
	);

	// read data; writes and unmapped offsets read zero
	always_comb begin
		rd = '0;
		if (!cmd_s1.command) begin
			unique case (cmd_s1.reg_offset)
				OFS_SCKCR:    rd = nxt.sckcr;
				OFS_SCKCR3:   rd = 32'(nxt.sckcr3);
				OFS_PLLCR:    rd = 32'(nxt.pllcr);
				OFS_PLLCR2:   rd = 32'(nxt.pll_stop);
				OFS_MOSCCR:   rd = 32'(nxt.main_stop);
				OFS_SOSCCR:   rd = 32'(nxt.sub_stop);
				OFS_LOCOCR:   rd = 32'(nxt.loco_stop);
				OFS_ILOCOCR:  rd = 32'(nxt.wdt_stop);
				OFS_HOCOCR:   rd = 32'(nxt.hoco_stop);
				OFS_OSCOVFSR: rd = {28'd0, fq.hoco_on, (fq.pll != '0), 1'b0, fq.main_on};
				OFS_CKOCR:    rd = 32'(nxt.ckocr);
				default:      rd = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			result_q.read_data            <= rd;
			result_q.iclk_hz              <= fq.iclk;
			result_q.fclk_hz              <= fq.fclk;
			result_q.pckb_hz              <= fq.pckb;
			result_q.pckd_hz              <= fq.pckd;
			result_q.pll_hz               <= fq.pll;
			result_q.clkout_hz            <= fq.clkout;
			result_q.write_refused        <= flags.refused;
			result_q.pll_in_out_of_range  <= fq.pll_in_err;
			result_q.pll_out_out_of_range <= fq.pll_out_err;
			result_q.illegal_setting      <= flags.illegal;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock generator register window: a mirror of
// the control registers and oscillators predicts the read data, derived
// clock frequencies and error flags of every transaction, and each report
// from the block is compared against it field by field.
// ----------------------------------------------------------------------------
module tb import ckg_pkg::*; ();

	localparam logic       CMD_READ  = 1'b0;
	localparam logic       CMD_WRITE = 1'b1;
	localparam logic [2:0] CFG_WDT   = 3'd4;

	class clock_tree_mirror;
		bit [24:0]   main_hz;
		bit [19:0]   sub_hz;
		bit [26:0]   loco_hz;
		bit [26:0]   hoco_hz;
		bit [19:0]   wdt_hz;
		bit [31:0]   sckcr;
		bit [15:0]   sckcr3;
		bit [2:0]    div_src;
		bit [15:0]   pllcr;
		bit          pll_stopped;
		bit          main_stop, sub_stop, loco_stop, hoco_stop, wdt_stop;
		bit [4:0]    running;
		bit [15:0]   ckocr;
		ckg_result_t clock_reports[$];
		int          mismatches;

		function new();
			mismatches = 0;
			main_hz = MAIN_HZ_RESET;
			sub_hz = SUB_HZ_RESET;
			loco_hz = LOCO_HZ_RESET;
			hoco_hz = HOCO_HZ_RESET;
			wdt_hz = 20'd15000;
			sckcr = SCKCR_RESET;
			sckcr3 = '0;
			div_src = SRC_LOCO;
			pllcr = PLLCR_RESET;
			pll_stopped = 1'b1;
			main_stop = 1'b1;
			sub_stop = 1'b0;
			loco_stop = 1'b0;
			hoco_stop = 1'b1;
			wdt_stop = 1'b1;
			running = RUN_RESET;
			ckocr = '0;
		endfunction

		function void set_osc(bit [2:0] idx, bit [26:0] v);
			case (idx)
				CFG_MAIN: main_hz = v[24:0];
				CFG_SUB:  sub_hz = v[19:0];
				CFG_LOCO: loco_hz = v;
				CFG_HOCO: hoco_hz = v;
				CFG_WDT:  wdt_hz = v[19:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] osc_hz(int idx, bit [31:0] hz);
			return running[idx] ? hz : 32'd0;
		endfunction

		function bit [63:0] pll_div(bit [1:0] code);
			return (code == PLL_DIV2) ? 64'd2 : ((code == PLL_DIV4) ? 64'd4 : 64'd1);
		endfunction

		function bit [63:0] pll_mul(bit [5:0] stc);
			return (stc == STC_X6) ? 64'd6 : ((stc == STC_X8) ? 64'd8 : 64'd1);
		endfunction

		function bit [31:0] pll_output();
			bit [63:0] f;
			if (pll_stopped)
				return 32'd0;
			f = 64'(osc_hz(RUN_MAIN, 32'(main_hz)));
			f = f * pll_mul(pllcr[13:8]);
			f = f / pll_div(pllcr[1:0]);
			return f[31:0];
		endfunction

		function bit [31:0] mux_hz();
			case (div_src)
				SRC_LOCO: return osc_hz(RUN_LOCO, 32'(loco_hz));
				SRC_HOCO: return osc_hz(RUN_HOCO, 32'(hoco_hz));
				SRC_MAIN: return osc_hz(RUN_MAIN, 32'(main_hz));
				SRC_SUB:  return osc_hz(RUN_SUB, 32'(sub_hz));
				SRC_PLL:  return pll_output();
				default:  return 32'd0;
			endcase
		endfunction

		function bit [31:0] bus_hz(bit [3:0] code);
			return mux_hz() >> ((code > BUS_DIV_MAX) ? 4'd0 : code);
		endfunction

		function bit [31:0] clkout_out();
			bit [2:0]  sel;
			bit [2:0]  dv;
			bit [31:0] f;
			sel = ckocr[10:8];
			dv = ckocr[14:12];
			if (ckocr[15] || sel > CKO_SRC_MAX || dv > CKO_DIV_MAX)
				return 32'd0;
			case (sel)
				SRC_LOCO: f = osc_hz(RUN_LOCO, 32'(loco_hz));
				SRC_HOCO: f = osc_hz(RUN_HOCO, 32'(hoco_hz));
				SRC_MAIN: f = osc_hz(RUN_MAIN, 32'(main_hz));
				default:  f = osc_hz(RUN_SUB, 32'(sub_hz));
			endcase
			return f >> dv;
		endfunction

		// apply one accepted transaction and queue the report it should produce
		function void note_access(ckg_cmd_t c);
			bit          wr;
			bit [31:0]   v;
			bit [31:0]   rd;
			bit [31:0]   pll;
			bit [31:0]   pin;
			bit          refused, illegal, pin_flag, pout_flag;
			ckg_result_t e;
			wr = (c.command == CMD_WRITE);
			v = c.write_data;
			rd = '0;
			refused = 1'b0;
			illegal = 1'b0;
			pin_flag = 1'b0;
			pout_flag = 1'b0;
			if (wr) begin
				case (c.reg_offset)
					OFS_SCKCR: begin
						if (v[31:28] > BUS_DIV_MAX || v[27:24] > BUS_DIV_MAX ||
						    v[11:8] > BUS_DIV_MAX || v[3:0] > BUS_DIV_MAX)
							illegal = 1'b1;
						sckcr = v & SCKCR_MASK;
					end
					OFS_SCKCR3: begin
						// an illegal source is stored but the mux keeps its old one
						if (v[10:8] <= SRC_MAX)
							div_src = v[10:8];
						else
							illegal = 1'b1;
						sckcr3 = v[15:0] & SCKCR3_MASK;
					end
					OFS_PLLCR: begin
						if (!pll_stopped) begin
							refused = 1'b1;
						end else begin
							pllcr = v[15:0] & PLLCR_MASK;
							if (pllcr[1:0] == PLL_DIV_BAD ||
							    (pllcr[13:8] != STC_X6 && pllcr[13:8] != STC_X8))
								illegal = 1'b1;
						end
					end
					OFS_PLLCR2: pll_stopped = v[0];
					OFS_MOSCCR: begin
						main_stop = v[0];
						running[RUN_MAIN] = !v[0];
					end
					OFS_SOSCCR: begin
						sub_stop = v[0];
						running[RUN_SUB] = !v[0];
					end
					OFS_LOCOCR: begin
						loco_stop = v[0];
						running[RUN_LOCO] = !v[0];
					end
					OFS_ILOCOCR: begin
						// stopping needs the stop bit to be clear first
						if (!v[0])
							running[RUN_WDT] = 1'b1;
						else if (!wdt_stop)
							running[RUN_WDT] = 1'b0;
						wdt_stop = v[0];
					end
					OFS_HOCOCR: begin
						hoco_stop = v[0];
						running[RUN_HOCO] = !v[0];
					end
					OFS_CKOCR: begin
						ckocr = v[15:0] & CKOCR_MASK;
						if (!v[15] && (v[10:8] > CKO_SRC_MAX || v[14:12] > CKO_DIV_MAX))
							illegal = 1'b1;
					end
					default: ;
				endcase
			end
			pll = pll_output();
			if (!wr) begin
				case (c.reg_offset)
					OFS_SCKCR:   rd = sckcr;
					OFS_SCKCR3:  rd = {16'd0, sckcr3};
					OFS_PLLCR:   rd = {16'd0, pllcr};
					OFS_PLLCR2:  rd = {31'd0, pll_stopped};
					OFS_MOSCCR:  rd = {31'd0, main_stop};
					OFS_SOSCCR:  rd = {31'd0, sub_stop};
					OFS_LOCOCR:  rd = {31'd0, loco_stop};
					OFS_ILOCOCR: rd = {31'd0, wdt_stop};
					OFS_HOCOCR:  rd = {31'd0, hoco_stop};
					OFS_OSCOVFSR: begin
						rd[0] = osc_hz(RUN_MAIN, 32'(main_hz)) != 0;
						rd[2] = pll != 0;
						rd[3] = osc_hz(RUN_HOCO, 32'(hoco_hz)) != 0;
					end
					OFS_CKOCR:   rd = {16'd0, ckocr};
					default:     rd = '0;
				endcase
			end
			if (!pll_stopped) begin
				pin = 32'(64'(osc_hz(RUN_MAIN, 32'(main_hz))) / pll_div(pllcr[1:0]));
				pin_flag = (pin > PLL_IN_MAX) || (pin < PLL_IN_MIN);
				pout_flag = (pll > PLL_OUT_MAX) || (pll < PLL_OUT_MIN);
			end
			e.read_data = rd;
			e.iclk_hz = bus_hz(sckcr[27:24]);
			e.fclk_hz = bus_hz(sckcr[31:28]);
			e.pckb_hz = bus_hz(sckcr[11:8]);
			e.pckd_hz = bus_hz(sckcr[3:0]);
			e.pll_hz = pll;
			e.clkout_hz = clkout_out();
			e.write_refused = refused;
			e.pll_in_out_of_range = pin_flag;
			e.pll_out_out_of_range = pout_flag;
			e.illegal_setting = illegal;
			clock_reports.push_back(e);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(ckg_result_t r);
			ckg_result_t e;
			if (clock_reports.size() == 0) begin
				$display("%0t: report expected none actual %h", $time, r);
				mismatches++;
				return;
			end
			e = clock_reports.pop_front();
			compare("read_data", e.read_data, r.read_data);
			compare("iclk_hz", e.iclk_hz, r.iclk_hz);
			compare("fclk_hz", e.fclk_hz, r.fclk_hz);
			compare("pckb_hz", e.pckb_hz, r.pckb_hz);
			compare("pckd_hz", e.pckd_hz, r.pckd_hz);
			compare("pll_hz", e.pll_hz, r.pll_hz);
			compare("clkout_hz", e.clkout_hz, r.clkout_hz);
			compare("write_refused", {31'd0, e.write_refused}, {31'd0, r.write_refused});
			compare("pll_in_out_of_range", {31'd0, e.pll_in_out_of_range},
				{31'd0, r.pll_in_out_of_range});
			compare("pll_out_out_of_range", {31'd0, e.pll_out_out_of_range},
				{31'd0, r.pll_out_out_of_range});
			compare("illegal_setting", {31'd0, e.illegal_setting},
				{31'd0, r.illegal_setting});
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	ckg_cmd_t    cmd;
	logic        done;
	ckg_result_t result;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [26:0] cfg_wdata;

	clock_tree_mirror mirror = new();

	clock_generator_registers u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("clock_generator_registers: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				mirror.set_osc(cfg_addr, cfg_wdata);
			if (start && !busy)
				mirror.note_access(cmd);
			if (done)
				mirror.check_report(result);
		end
	end

	function automatic ckg_cmd_t access(logic c, logic [15:0] ofs, logic [31:0] d);
		ckg_cmd_t t;
		t.command = c;
		t.reg_offset = ofs;
		t.write_data = d;
		return t;
	endfunction

	function automatic logic [3:0] bus_code();
		return ($urandom_range(9) == 0) ? 4'($urandom_range(15, 7)) : 4'($urandom_range(6));
	endfunction

	// mostly legal field codes inside otherwise random write data
	function automatic logic [31:0] shape(logic [15:0] ofs, logic [31:0] d);
		logic [31:0] v;
		v = d;
		if ($urandom_range(3) == 0)
			return v;
		case (ofs)
			OFS_SCKCR: begin
				v[31:28] = bus_code();
				v[27:24] = bus_code();
				v[11:8] = bus_code();
				v[3:0] = bus_code();
			end
			OFS_SCKCR3: v[10:8] = 3'($urandom_range(SRC_MAX));
			OFS_PLLCR: begin
				v[13:8] = $urandom_range(1) ? STC_X6 : STC_X8;
				v[1:0] = 2'($urandom_range(2));
			end
			OFS_CKOCR: begin
				v[15] = ($urandom_range(3) == 0);
				v[14:12] = 3'($urandom_range(CKO_DIV_MAX));
				v[10:8] = 3'($urandom_range(CKO_SRC_MAX));
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic ckg_cmd_t rand_command();
		logic [15:0] ofs;
		case ($urandom_range(13))
			0:  ofs = OFS_SCKCR;
			1:  ofs = OFS_SCKCR3;
			2:  ofs = OFS_PLLCR;
			3:  ofs = OFS_PLLCR2;
			4:  ofs = OFS_MOSCCR;
			5:  ofs = OFS_SOSCCR;
			6:  ofs = OFS_LOCOCR;
			7:  ofs = OFS_ILOCOCR;
			8:  ofs = OFS_HOCOCR;
			9:  ofs = OFS_OSCOVFSR;
			10: ofs = OFS_CKOCR;
			11: ofs = 16'($urandom_range(255));
			default: ofs = 16'($urandom);
		endcase
		return access(1'($urandom_range(1)), ofs, shape(ofs, $urandom));
	endfunction

	task automatic bus_access(input ckg_cmd_t c, input int gap_pct);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (mirror.clock_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_oscillators(input logic [26:0] main_v, input logic [26:0] sub_v,
		input logic [26:0] loco_v, input logic [26:0] hoco_v, input logic [26:0] wdt_v);
		logic [26:0] vals [5];
		vals[0] = main_v;
		vals[1] = sub_v;
		vals[2] = loco_v;
		vals[3] = hoco_v;
		vals[4] = wdt_v;
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 3'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_directed();
		bus_access(access(CMD_READ, OFS_SCKCR, '0), 0);
		bus_access(access(CMD_READ, OFS_SCKCR3, '1), 0);
		bus_access(access(CMD_READ, OFS_PLLCR, '0), 0);
		bus_access(access(CMD_READ, OFS_PLLCR2, '0), 0);
		bus_access(access(CMD_READ, OFS_CKOCR, '0), 0);
		bus_access(access(CMD_WRITE, OFS_MOSCCR, 32'h0), 0);
		// bad divider and bad multiplier together
		bus_access(access(CMD_WRITE, OFS_PLLCR, 32'hffff_ffff), 0);
		bus_access(access(CMD_WRITE, OFS_PLLCR, 32'h0000_0b00), 0);
		bus_access(access(CMD_WRITE, OFS_PLLCR2, 32'h0), 0);
		bus_access(access(CMD_READ, OFS_OSCOVFSR, '0), 0);
		// pll running: refused
		bus_access(access(CMD_WRITE, OFS_PLLCR, 32'h0000_0f02), 0);
		bus_access(access(CMD_WRITE, OFS_PLLCR2, 32'h1), 0);
		bus_access(access(CMD_WRITE, OFS_PLLCR, 32'h0000_0f02), 0);
		bus_access(access(CMD_WRITE, OFS_PLLCR2, 32'h0), 0);
		bus_access(access(CMD_WRITE, OFS_SCKCR3, 32'h0000_0400), 0);
		bus_access(access(CMD_WRITE, OFS_SCKCR3, 32'hffff_ffff), 0);
		bus_access(access(CMD_WRITE, OFS_SCKCR, 32'hffff_ffff), 0);
		bus_access(access(CMD_WRITE, OFS_SCKCR, 32'h6600_0606), 0);
		bus_access(access(CMD_WRITE, OFS_HOCOCR, 32'h0), 0);
		bus_access(access(CMD_WRITE, OFS_CKOCR, 32'h0000_4100), 0);
		bus_access(access(CMD_WRITE, OFS_CKOCR, 32'h0000_5400), 0);
		bus_access(access(CMD_WRITE, OFS_CKOCR, 32'hffff_ffff), 0);
		bus_access(access(CMD_WRITE, OFS_ILOCOCR, 32'h1), 0);
		bus_access(access(CMD_WRITE, OFS_ILOCOCR, 32'h0), 0);
		bus_access(access(CMD_WRITE, OFS_SOSCCR, 32'h1), 0);
		bus_access(access(CMD_WRITE, OFS_LOCOCR, 32'h1), 0);
		bus_access(access(CMD_READ, 16'hffff, '1), 0);
		bus_access(access(CMD_WRITE, OFS_OSCOVFSR, '1), 0);
	endtask

	task automatic run_random(input int count, input int gap_pct);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 30) begin
				// pll bring-up; skipping the stop step can make the pllcr write bounce
				if ($urandom_range(4) != 0)
					bus_access(access(CMD_WRITE, OFS_PLLCR2, $urandom | 32'h1), gap_pct);
				bus_access(access(CMD_WRITE, OFS_PLLCR, shape(OFS_PLLCR, $urandom)), gap_pct);
				bus_access(access(CMD_WRITE, OFS_MOSCCR,
					($urandom_range(7) == 0) ? $urandom : ($urandom & ~32'h1)), gap_pct);
				bus_access(access(CMD_WRITE, OFS_PLLCR2, $urandom & ~32'h1), gap_pct);
				bus_access(access(CMD_WRITE, OFS_SCKCR3, shape(OFS_SCKCR3, $urandom)), gap_pct);
				bus_access(access(CMD_WRITE, OFS_SCKCR, shape(OFS_SCKCR, $urandom)), gap_pct);
				bus_access(access(CMD_READ, OFS_OSCOVFSR, $urandom), gap_pct);
				sent += 7;
			end else begin
				bus_access(rand_command(), gap_pct);
				sent++;
			end
		end
	endtask

	initial begin
		logic [26:0] main_v;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_oscillators(27'd16000000, 27'd32768, 27'd4000000, 27'd32000000, 27'd15000);
		run_directed();
		run_random(630, 19);
		settle();

		set_oscillators(27'd20000000, 27'd1000000, 27'd100000000, 27'd100000000,
			27'd1000000);
		run_random(630, 78);
		settle();

		for (int k = 0; k < 4; k++) begin
			if (k == 0) begin
				set_oscillators('0, '0, '0, '0, '0);
			end else begin
				case ($urandom_range(5))
					0: main_v = 27'd4000000;
					1: main_v = 27'd8000000;
					2: main_v = 27'd12000000;
					3: main_v = 27'd16000000;
					4: main_v = 27'd20000000;
					default: main_v = 27'($urandom_range(20000000));
				endcase
				set_oscillators(main_v, 27'($urandom_range(1000000)),
					27'($urandom_range(100000000)), 27'($urandom_range(100000000)),
					27'($urandom_range(1000000)));
			end
			run_random(160, 0);
			settle();
		end

		if (mirror.mismatches == 0)
			$display("clock_generator_registers: match");
		else
			$display("clock_generator_registers: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
sv/ckg_pkg.sv
sv/ckg_regs.sv
sv/ckg_freq.sv
sv/clock_generator_registers.sv
tb/tb.sv
